// File: hw/rtl/dhcp_reply_parser_assert.svh
// Assertion macros used by the DHCP reply parser top level.
`ifndef DHCP_REPLY_PARSER_ASSERT_SVH
`define DHCP_REPLY_PARSER_ASSERT_SVH

// Same-cycle implication, checked on clk and held off during rst.
`define DRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on clk and held off during rst.
`define DRP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/drp_pkg.sv
// Types and constants shared by the DHCP reply parser modules.
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

  localparam int MAX_PAYLOAD_BYTES = 2048;
  localparam int OPTIONS_OFFSET    = 240;
  localparam int IDX_W             = $clog2(MAX_PAYLOAD_BYTES + 1);

  localparam logic [7:0]  OP_REPLY    = 8'd2;
  localparam logic [15:0] SERVER_PORT = 16'd67;

  localparam logic [7:0] OPT_PAD    = 8'd0;
  localparam logic [7:0] OPT_MASK   = 8'd1;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS    = 8'd6;
  localparam logic [7:0] OPT_TYPE   = 8'd53;
  localparam logic [7:0] OPT_SERVER = 8'd54;
  localparam logic [7:0] OPT_END    = 8'd255;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_REPLY = 2'd1;
  localparam logic [1:0] ST_ID_BAD    = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  localparam logic REG_CLIENT_MAC = 1'b0;
  localparam logic REG_XID        = 1'b1;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [15:0] source_port;
    logic [31:0] source_ip;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  message_type;
    logic [31:0] offered_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [31:0] dns_ip;
    logic [31:0] server_ip;
  } out_item_t;

  typedef struct packed {
    logic [47:0] client_mac;
    logic [31:0] transaction_id;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/drp_cfg.sv
// Configuration register file with an APB-style slave port.
`timescale 1ns / 1ps
`default_nettype none

module drp_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output drp_pkg::cfg_t     cfg
);

  logic        wr_en;
  logic        reg_sel;
  logic [47:0] client_mac;
  logic [31:0] transaction_id;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_mac     <= '0;
      transaction_id <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        drp_pkg::REG_CLIENT_MAC: client_mac     <= pwdata[47:0];
        drp_pkg::REG_XID:        transaction_id <= pwdata[31:0];
        default:                 client_mac     <= client_mac;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      drp_pkg::REG_CLIENT_MAC: prdata = {16'd0, client_mac};
      drp_pkg::REG_XID:        prdata = {32'd0, transaction_id};
      default:                 prdata = '0;
    endcase
  end

  assign cfg.client_mac     = client_mac;
  assign cfg.transaction_id = transaction_id;

endmodule

`default_nettype wire

// File: hw/rtl/drp_parse.sv
// Per-byte header check and option walk with the stored lease values.
`timescale 1ns / 1ps
`default_nettype none

module drp_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire drp_pkg::in_item_t  item,
  input  wire drp_pkg::cfg_t      cfg,
  output drp_pkg::out_item_t      result
);

  logic [drp_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [1:0]                header_status, header_status_next;
  logic [31:0]               candidate_ip, candidate_ip_next;
  drp_pkg::phase_t           option_phase, option_phase_next;
  logic [7:0]                option_code, option_code_next;
  logic [7:0]                option_remaining, option_remaining_next;
  logic [2:0]                value_position, value_position_next;
  logic                      server_write_enable, server_write_enable_next;
  logic [7:0]                type_seen, type_seen_next;
  logic [31:0]               lease_ip, lease_ip_next;
  logic [31:0]               mask_store, mask_store_next;
  logic [31:0]               router_store, router_store_next;
  logic [31:0]               dns_store, dns_store_next;
  logic [31:0]               server_store, server_store_next;

  logic                      active;
  logic                      opt_byte;
  logic [7:0]                b;
  logic [7:0]                want_xid;
  logic [7:0]                want_mac;
  logic [7:0]                rem_dec;
  logic [31:0]               cand_shift;
  logic [1:0]                final_status;

  assign b          = item.payload_byte;
  assign active     = byte_index < drp_pkg::IDX_W'(drp_pkg::MAX_PAYLOAD_BYTES);
  assign rem_dec    = option_remaining - 8'd1;
  assign cand_shift = {candidate_ip[23:0], b};
  assign opt_byte   = step && active && (byte_index != '0) &&
                      (header_status == drp_pkg::ST_OK) &&
                      (byte_index >= drp_pkg::IDX_W'(drp_pkg::OPTIONS_OFFSET));

  always_comb begin
    unique case (byte_index[1:0])
      2'd0:    want_xid = cfg.transaction_id[31:24];
      2'd1:    want_xid = cfg.transaction_id[23:16];
      2'd2:    want_xid = cfg.transaction_id[15:8];
      default: want_xid = cfg.transaction_id[7:0];
    endcase
  end

  // chaddr bytes 28..33 map onto the low three index bits 4,5,6,7,0,1
  always_comb begin
    unique case (byte_index[2:0])
      3'd4:    want_mac = cfg.client_mac[47:40];
      3'd5:    want_mac = cfg.client_mac[39:32];
      3'd6:    want_mac = cfg.client_mac[31:24];
      3'd7:    want_mac = cfg.client_mac[23:16];
      3'd0:    want_mac = cfg.client_mac[15:8];
      default: want_mac = cfg.client_mac[7:0];
    endcase
  end

  // Option walk: next phase
  always_comb begin
    option_phase_next = option_phase;
    if (opt_byte) begin
      unique case (option_phase)
        drp_pkg::PH_CODE: begin
          if (b == drp_pkg::OPT_END) begin
            option_phase_next = drp_pkg::PH_DONE;
          end else if (b != drp_pkg::OPT_PAD) begin
            option_phase_next = drp_pkg::PH_LEN;
          end
        end
        drp_pkg::PH_LEN: begin
          option_phase_next = (b != 8'd0) ? drp_pkg::PH_VALUE : drp_pkg::PH_CODE;
        end
        drp_pkg::PH_VALUE: begin
          if (rem_dec == 8'd0) begin
            option_phase_next = drp_pkg::PH_CODE;
          end
        end
        default: option_phase_next = option_phase;
      endcase
    end
    if (step && item.last_byte) begin
      option_phase_next = drp_pkg::PH_CODE;
    end
  end

  // Header checks, option capture and result
  always_comb begin
    byte_index_next          = byte_index;
    header_status_next       = header_status;
    candidate_ip_next        = candidate_ip;
    option_code_next         = option_code;
    option_remaining_next    = option_remaining;
    value_position_next      = value_position;
    server_write_enable_next = server_write_enable;
    type_seen_next           = type_seen;
    lease_ip_next            = lease_ip;
    mask_store_next          = mask_store;
    router_store_next        = router_store;
    dns_store_next           = dns_store;
    server_store_next        = server_store;

    if (step && active) begin
      byte_index_next = byte_index + 1'b1;
      if (byte_index == '0) begin
        if (b != drp_pkg::OP_REPLY || item.source_port != drp_pkg::SERVER_PORT) begin
          header_status_next = drp_pkg::ST_NOT_REPLY;
        end
      end else if (header_status == drp_pkg::ST_OK) begin
        if (byte_index >= drp_pkg::IDX_W'(4) && byte_index <= drp_pkg::IDX_W'(7)) begin
          if (b != want_xid) header_status_next = drp_pkg::ST_ID_BAD;
        end else if (byte_index >= drp_pkg::IDX_W'(16) &&
                     byte_index <= drp_pkg::IDX_W'(19)) begin
          candidate_ip_next = cand_shift;
        end else if (byte_index >= drp_pkg::IDX_W'(28) &&
                     byte_index <= drp_pkg::IDX_W'(33)) begin
          if (b != want_mac) begin
            header_status_next = drp_pkg::ST_ID_BAD;
          end else if (byte_index == drp_pkg::IDX_W'(33)) begin
            lease_ip_next = candidate_ip;
          end
        end else if (opt_byte) begin
          unique case (option_phase)
            drp_pkg::PH_CODE: begin
              if (b != drp_pkg::OPT_END && b != drp_pkg::OPT_PAD) option_code_next = b;
            end
            drp_pkg::PH_LEN: begin
              option_remaining_next = b;
              value_position_next   = '0;
              candidate_ip_next     = '0;
              if (option_code == drp_pkg::OPT_SERVER) begin
                server_write_enable_next = (server_store == '0) ||
                                           (server_store == item.source_ip);
              end
            end
            drp_pkg::PH_VALUE: begin
              if (value_position == 3'd0 && option_code == drp_pkg::OPT_TYPE) begin
                type_seen_next = b;
              end
              if (value_position < 3'd4) begin
                candidate_ip_next   = cand_shift;
                value_position_next = value_position + 3'd1;
                if (value_position == 3'd3) begin
                  if (option_code == drp_pkg::OPT_MASK) begin
                    mask_store_next = cand_shift;
                  end else if (option_code == drp_pkg::OPT_ROUTER) begin
                    router_store_next = cand_shift;
                  end else if (option_code == drp_pkg::OPT_DNS) begin
                    dns_store_next = cand_shift;
                  end else if (option_code == drp_pkg::OPT_SERVER && server_write_enable) begin
                    server_store_next = cand_shift;
                  end
                end
              end
              option_remaining_next = rem_dec;
            end
            default: option_code_next = option_code;
          endcase
        end
      end
    end

    final_status = header_status_next;
    if (final_status == drp_pkg::ST_OK &&
        byte_index < drp_pkg::IDX_W'(drp_pkg::OPTIONS_OFFSET - 1)) begin
      final_status = drp_pkg::ST_TRUNC;
    end
    result.status       = final_status;
    result.message_type = (final_status == drp_pkg::ST_OK) ? type_seen_next : 8'd0;
    result.offered_ip   = lease_ip_next;
    result.subnet_mask  = mask_store_next;
    result.gateway_ip   = router_store_next;
    result.dns_ip       = dns_store_next;
    result.server_ip    = server_store_next;

    // Per-packet state starts afresh after the closing byte
    if (step && item.last_byte) begin
      byte_index_next          = '0;
      header_status_next       = drp_pkg::ST_OK;
      candidate_ip_next        = '0;
      option_code_next         = '0;
      option_remaining_next    = '0;
      value_position_next      = '0;
      server_write_enable_next = 1'b0;
      type_seen_next           = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index          <= '0;
      header_status       <= drp_pkg::ST_OK;
      candidate_ip        <= '0;
      option_phase        <= drp_pkg::PH_CODE;
      option_code         <= '0;
      option_remaining    <= '0;
      value_position      <= '0;
      server_write_enable <= 1'b0;
      type_seen           <= '0;
      lease_ip            <= '0;
      mask_store          <= '0;
      router_store        <= '0;
      dns_store           <= '0;
      server_store        <= '0;
    end else begin
      byte_index          <= byte_index_next;
      header_status       <= header_status_next;
      candidate_ip        <= candidate_ip_next;
      option_phase        <= option_phase_next;
      option_code         <= option_code_next;
      option_remaining    <= option_remaining_next;
      value_position      <= value_position_next;
      server_write_enable <= server_write_enable_next;
      type_seen           <= type_seen_next;
      lease_ip            <= lease_ip_next;
      mask_store          <= mask_store_next;
      router_store        <= router_store_next;
      dns_store           <= dns_store_next;
      server_store        <= server_store_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dhcp_reply_parser.sv
// The result is captured in the output register as the byte marked last is parsed.
// Throughput: 1 payload byte per cycle when no byte waits, as below; the per-byte
// parse step is the only loop. A byte waits in the input register only when it
// closes a packet and the previous result is still held in the output register.
// Reset (rst, synchronous, active high) clears both registers' valids, the
// parse state, the stored lease values and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
`include "dhcp_reply_parser_assert.svh"

module dhcp_reply_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  // input byte channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire drp_pkg::in_item_t   in_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output drp_pkg::out_item_t       out_data,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [63:0]         pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);

  drp_pkg::cfg_t      cfg;
  drp_pkg::in_item_t  hold_item;
  drp_pkg::out_item_t result;
  logic               hold_valid;
  logic               step;
  logic               in_xfer;
  logic               out_free;

  // Output register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  // Advance the held byte unless it closes a packet and the result slot is taken
  assign step     = hold_valid && (!hold_item.last_byte || out_free);
  assign in_stall = hold_valid && !step;
  assign in_xfer  = in_valid && !in_stall;

  drp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  // Input register: load on every transfer, drop the valid once consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_xfer) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_item <= in_data;
    end
  end

  // Output register: capture the summary on a closing byte, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && hold_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hold_item.last_byte) begin
      out_data <= result;
    end
  end

  `DRP_ASSERT_IMP(a_stall_needs_item, in_stall, hold_valid)
  `DRP_ASSERT_IMP(a_stall_only_on_close, in_stall, hold_item.last_byte && !out_free)
  `DRP_ASSERT_NXT(a_close_gives_result, step && hold_item.last_byte, out_valid)
  `DRP_ASSERT_IMP(a_type_only_when_ok, out_valid,
                  out_data.status == drp_pkg::ST_OK || out_data.message_type == 8'd0)

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for dhcp_reply_parser: byte streams in, parsed replies checked.
`timescale 1ns / 1ps

module tb;

  // Frame offsets inside the fixed BOOTP header
  localparam int XID_AT    = 4;
  localparam int YIADDR_AT = 16;
  localparam int CHADDR_AT = 28;

  // Register byte addresses (registers are 64 bits apart, the MAC being 48 bits)
  localparam logic [3:0] ADDR_MAC = {drp_pkg::REG_CLIENT_MAC, 3'b000};
  localparam logic [3:0] ADDR_XID = {drp_pkg::REG_XID, 3'b000};

  localparam int SETTLE_CYCLES = 6;       // settle time after each phase, with margin
  localparam int HOLD_OFF      = 400;     // long receiver stall during the flood
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  drp_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  drp_pkg::out_item_t  out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [63:0]         pwdata = '0;
  logic [63:0]         prdata;
  logic                pready;

  dhcp_reply_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: configuration, per-packet walk state and the held lease values
  // ---------------------------------------------------------------------------
  logic [47:0]      cfg_mac = '0;
  logic [31:0]      cfg_xid = '0;

  int               byte_pos = 0;
  logic [1:0]       hdr_status = drp_pkg::ST_OK;
  logic [31:0]      cand_ip = '0;
  drp_pkg::phase_t  opt_phase = drp_pkg::PH_CODE;
  logic [7:0]       opt_code = '0;
  logic [7:0]       opt_left = '0;
  logic [7:0]       val_pos = '0;
  logic             server_we = 1'b0;
  logic [7:0]       type_seen = '0;
  logic [31:0]      held_lease = '0;
  logic [31:0]      held_mask = '0;
  logic [31:0]      held_router = '0;
  logic [31:0]      held_dns = '0;
  logic [31:0]      held_server = '0;

  drp_pkg::out_item_t expected_replies[$];
  drp_pkg::in_item_t  byte_queue[$];
  logic [7:0]         pkt[$];
  logic [31:0]        ip_pool[4];

  int bytes_queued = 0;
  int bytes_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic flooding = 1'b0;

  // Advance the shadow parser by one transferred byte; queue the reply on the last one.
  function automatic void parse_reply_byte(input drp_pkg::in_item_t it);
    int                 idx;
    logic [7:0]         b;
    logic [1:0]         st;
    drp_pkg::out_item_t res;
    idx = byte_pos;
    b = it.payload_byte;
    if (idx < drp_pkg::MAX_PAYLOAD_BYTES) begin
      byte_pos = idx + 1;
      if (idx == 0) begin
        if (b != drp_pkg::OP_REPLY || it.source_port != drp_pkg::SERVER_PORT)
          hdr_status = drp_pkg::ST_NOT_REPLY;
      end else if (hdr_status == drp_pkg::ST_OK) begin
        if (idx >= XID_AT && idx <= XID_AT + 3) begin
          if (b != cfg_xid[8 * (XID_AT + 3 - idx) +: 8]) hdr_status = drp_pkg::ST_ID_BAD;
        end else if (idx >= YIADDR_AT && idx <= YIADDR_AT + 3) begin
          cand_ip = {cand_ip[23:0], b};
        end else if (idx >= CHADDR_AT && idx <= CHADDR_AT + 5) begin
          if (b != cfg_mac[8 * (CHADDR_AT + 5 - idx) +: 8]) hdr_status = drp_pkg::ST_ID_BAD;
          if (idx == CHADDR_AT + 5 && hdr_status == drp_pkg::ST_OK) held_lease = cand_ip;
        end else if (idx >= drp_pkg::OPTIONS_OFFSET) begin
          case (opt_phase)
            drp_pkg::PH_CODE: begin
              if (b == drp_pkg::OPT_END) begin
                opt_phase = drp_pkg::PH_DONE;
              end else if (b != drp_pkg::OPT_PAD) begin
                opt_code = b;
                opt_phase = drp_pkg::PH_LEN;
              end
            end
            drp_pkg::PH_LEN: begin
              opt_left = b;
              val_pos = '0;
              cand_ip = '0;
              if (opt_code == drp_pkg::OPT_SERVER)
                server_we = (held_server == '0) || (held_server == it.source_ip);
              opt_phase = (b != 8'h00) ? drp_pkg::PH_VALUE : drp_pkg::PH_CODE;
            end
            drp_pkg::PH_VALUE: begin
              if (val_pos == 8'd0 && opt_code == drp_pkg::OPT_TYPE) type_seen = b;
              if (val_pos < 8'd4) begin
                cand_ip = {cand_ip[23:0], b};
                if (val_pos == 8'd3) begin
                  case (opt_code)
                    drp_pkg::OPT_MASK:   held_mask = cand_ip;
                    drp_pkg::OPT_ROUTER: held_router = cand_ip;
                    drp_pkg::OPT_DNS:    held_dns = cand_ip;
                    drp_pkg::OPT_SERVER: if (server_we) held_server = cand_ip;
                    default: ;
                  endcase
                end
                val_pos = val_pos + 8'd1;
              end
              opt_left = opt_left - 8'd1;
              if (opt_left == 8'd0) opt_phase = drp_pkg::PH_CODE;
            end
            default: ;
          endcase
        end
      end
    end
    if (it.last_byte) begin
      st = hdr_status;
      if (st == drp_pkg::ST_OK && idx < drp_pkg::OPTIONS_OFFSET - 1) st = drp_pkg::ST_TRUNC;
      res.status       = st;
      res.message_type = (st == drp_pkg::ST_OK) ? type_seen : 8'h00;
      res.offered_ip   = held_lease;
      res.subnet_mask  = held_mask;
      res.gateway_ip   = held_router;
      res.dns_ip       = held_dns;
      res.server_ip    = held_server;
      expected_replies.push_back(res);
      byte_pos   = 0;
      hdr_status = drp_pkg::ST_OK;
      cand_ip    = '0;
      opt_phase  = drp_pkg::PH_CODE;
      opt_code   = '0;
      opt_left   = '0;
      val_pos    = '0;
      server_we  = 1'b0;
      type_seen  = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch on %s: got %h, want %h", what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Configuration writes: setup cycle, then access until pready
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAC) cfg_mac = data[47:0];
    else if (addr == ADDR_XID) cfg_xid = data[31:0];
  endtask

  task automatic write_setting(input logic [47:0] mac, input logic [31:0] xid);
    write_reg(ADDR_MAC, {16'h0000, mac});
    write_reg(ADDR_XID, {32'h0, xid});
  endtask

  // Hold until every queued byte is transferred and every reply has come back.
  task automatic finish_phase();
    while (bytes_taken != bytes_queued || expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Packet building
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_ip();
    return ($urandom_range(0, 3) == 0) ? 32'($urandom) : ip_pool[$urandom_range(0, 3)];
  endfunction

  // Well-formed header for the current setting: random filler, random yiaddr.
  task automatic start_reply();
    pkt.delete();
    repeat (drp_pkg::OPTIONS_OFFSET) pkt.push_back(8'($urandom));
    pkt[0] = drp_pkg::OP_REPLY;
    for (int k = 0; k < 4; k++) pkt[XID_AT + k] = cfg_xid[8 * (3 - k) +: 8];
    for (int k = 0; k < 6; k++) pkt[CHADDR_AT + k] = cfg_mac[8 * (5 - k) +: 8];
  endtask

  // Append code, length and value; the first four value bytes come from value.
  task automatic add_option(input logic [7:0] code, input int len, input logic [31:0] value);
    logic [31:0] v;
    v = value;
    pkt.push_back(code);
    pkt.push_back(8'(len));
    for (int k = 0; k < len; k++) begin
      pkt.push_back((k < 4) ? v[31:24] : 8'($urandom));
      v = v << 8;
    end
  endtask

  task automatic cut_to(input int len);
    while (pkt.size() > len) void'(pkt.pop_back());
  endtask

  function automatic logic [7:0] pick_option_code();
    case ($urandom_range(0, 9))
      0:       return drp_pkg::OPT_MASK;
      1:       return drp_pkg::OPT_ROUTER;
      2:       return drp_pkg::OPT_DNS;
      3, 4:    return drp_pkg::OPT_TYPE;
      5, 6:    return drp_pkg::OPT_SERVER;
      7:       return drp_pkg::OPT_PAD;
      8:       return drp_pkg::OPT_END;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_random_options(input int count);
    logic [7:0]  code;
    int          len;
    logic [31:0] value;
    for (int n = 0; n < count; n++) begin
      code = pick_option_code();
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : 4;
      case (code)
        drp_pkg::OPT_PAD: pkt.push_back(drp_pkg::OPT_PAD);
        drp_pkg::OPT_END: begin
          // close the walk, then trail junk that must be ignored
          pkt.push_back(drp_pkg::OPT_END);
          repeat ($urandom_range(0, 16)) pkt.push_back(8'($urandom));
          return;
        end
        drp_pkg::OPT_TYPE: add_option(code, (len == 4) ? 1 : $urandom_range(0, 3), $urandom);
        drp_pkg::OPT_SERVER: begin
          case ($urandom_range(0, 3))
            0:       value = '0;
            1:       value = pick_ip();
            default: value = $urandom;
          endcase
          add_option(code, len, value);
        end
        default: add_option(code, len, $urandom);
      endcase
    end
  endtask

  // Turn pkt into transfers, last flag on the final byte.
  task automatic send_packet(input logic [15:0] port, input logic [31:0] ip);
    drp_pkg::in_item_t it;
    for (int k = 0; k < pkt.size(); k++) begin
      it.payload_byte = pkt[k];
      it.last_byte    = (k == pkt.size() - 1);
      it.source_port  = port;
      it.source_ip    = ip;
      byte_queue.push_back(it);
    end
    bytes_queued += pkt.size();
  endtask

  // Half the time a good reply with random options, sometimes cut short; the rest broken or plain noise.
  task automatic send_random_reply();
    logic [15:0] port;
    logic [31:0] ip;
    int          spot;
    port = drp_pkg::SERVER_PORT;
    ip = pick_ip();
    start_reply();
    add_random_options($urandom_range(1, 10));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        // sometimes cut an option off mid-value
        if ($urandom_range(0, 3) == 0)
          cut_to($urandom_range(drp_pkg::OPTIONS_OFFSET, pkt.size()));
      end
      5: begin
        pkt[0] = 8'($urandom);
        if (pkt[0] == drp_pkg::OP_REPLY) pkt[0] ^= 8'h80;
        cut_to($urandom_range(1, pkt.size()));
      end
      6: begin
        port = 16'($urandom);
        if (port == drp_pkg::SERVER_PORT) port ^= 16'h8000;
        cut_to($urandom_range(1, pkt.size()));
      end
      7: begin
        spot = $urandom_range(0, 1) ? $urandom_range(XID_AT, XID_AT + 3)
                                    : $urandom_range(CHADDR_AT, CHADDR_AT + 5);
        pkt[spot] ^= 8'(1 << $urandom_range(0, 7));
        cut_to($urandom_range(1, pkt.size()));
      end
      8: cut_to($urandom_range(1, drp_pkg::OPTIONS_OFFSET - 1));
      default: begin
        pkt.delete();
        repeat ($urandom_range(1, 300)) pkt.push_back(8'($urandom));
        port = $urandom_range(0, 1) ? drp_pkg::SERVER_PORT : 16'($urandom);
        ip = $urandom;
      end
    endcase
    send_packet(port, ip);
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // a transfer happened at this edge: feed it to the shadow parser
      if (in_valid && !in_stall) begin
        parse_reply_byte(in_data);
        bytes_taken++;
      end
      // hold the payload while stalled, otherwise present the next byte or idle
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          in_data  <= byte_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            // long stretch with no idling at all
            burst_left = $urandom_range(100, 400);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: a random pattern, re-chosen whenever its random run ends, plus a
  // long hold-off when the flood phase starts so that the block backs up
  // ---------------------------------------------------------------------------
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  logic     flood_prev = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (flooding && !flood_prev) hold_left = HOLD_OFF;
      flood_prev = flooding;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_stall <= ~out_stall;
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reply monitor: compare each transfer against the oldest pending reply
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    drp_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with none pending", 32'(out_data.status), '0);
      end else begin
        want = expected_replies.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.message_type !== want.message_type)
          report_mismatch("message_type", 32'(out_data.message_type), 32'(want.message_type));
        if (out_data.offered_ip !== want.offered_ip)
          report_mismatch("offered_ip", out_data.offered_ip, want.offered_ip);
        if (out_data.subnet_mask !== want.subnet_mask)
          report_mismatch("subnet_mask", out_data.subnet_mask, want.subnet_mask);
        if (out_data.gateway_ip !== want.gateway_ip)
          report_mismatch("gateway_ip", out_data.gateway_ip, want.gateway_ip);
        if (out_data.dns_ip !== want.dns_ip)
          report_mismatch("dns_ip", out_data.dns_ip, want.dns_ip);
        if (out_data.server_ip !== want.server_ip)
          report_mismatch("server_ip", out_data.server_ip, want.server_ip);
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int round;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    ip_pool[2] = $urandom | 32'h1;
    ip_pool[3] = $urandom | 32'h2;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_setting({16'($urandom), 32'($urandom)}, $urandom);

    // Lone first byte: a reply too short for anything, then a wrong port.
    pkt.delete();
    pkt.push_back(drp_pkg::OP_REPLY);
    send_packet(drp_pkg::SERVER_PORT, '0);
    pkt.delete();
    pkt.push_back(drp_pkg::OP_REPLY);
    send_packet(16'hFFFF, '1);

    // Wrong op code; then right op code from the wrong port.
    start_reply();
    pkt[0] = 8'hFF;
    cut_to(CHADDR_AT + 8);
    send_packet(drp_pkg::SERVER_PORT, ip_pool[2]);
    start_reply();
    cut_to(CHADDR_AT + 8);
    send_packet(16'h0000, ip_pool[2]);

    // xid off in its last byte; chaddr off in its first byte.
    start_reply();
    pkt[XID_AT + 3] ^= 8'h01;
    cut_to(CHADDR_AT + 8);
    send_packet(drp_pkg::SERVER_PORT, ip_pool[2]);
    start_reply();
    pkt[CHADDR_AT] ^= 8'h80;
    cut_to(CHADDR_AT + 8);
    send_packet(drp_pkg::SERVER_PORT, ip_pool[2]);

    // Truncated right after chaddr: the lease is still committed.
    start_reply();
    cut_to(CHADDR_AT + 6);
    send_packet(drp_pkg::SERVER_PORT, ip_pool[2]);

    // Last byte one short of the option area, then exactly at its edge.
    start_reply();
    cut_to(drp_pkg::OPTIONS_OFFSET - 1);
    send_packet(drp_pkg::SERVER_PORT, ip_pool[2]);
    start_reply();
    send_packet(drp_pkg::SERVER_PORT, ip_pool[2]);

    // Every captured option with pads between; anything after end is ignored.
    start_reply();
    pkt.push_back(drp_pkg::OPT_PAD);
    add_option(drp_pkg::OPT_MASK, 4, 32'hFFFF_FF00);
    pkt.push_back(drp_pkg::OPT_PAD);
    add_option(drp_pkg::OPT_ROUTER, 4, $urandom);
    add_option(drp_pkg::OPT_DNS, 4, 32'hFFFF_FFFF);
    add_option(drp_pkg::OPT_TYPE, 1, 32'h0500_0000);
    add_option(drp_pkg::OPT_SERVER, 4, ip_pool[2]);
    pkt.push_back(drp_pkg::OPT_END);
    add_option(drp_pkg::OPT_MASK, 4, 32'h0);
    send_packet(drp_pkg::SERVER_PORT, ip_pool[2]);

    // Odd lengths, an unknown code, a server id from a foreign source,
    // a repeated option and a value cut off by the end of the packet.
    start_reply();
    add_option(drp_pkg::OPT_MASK, 2, $urandom);
    add_option(drp_pkg::OPT_ROUTER, 7, $urandom);
    add_option(drp_pkg::OPT_TYPE, 0, '0);
    add_option(drp_pkg::OPT_DNS, 0, '0);
    add_option(drp_pkg::OPT_TYPE, 3, {8'hFF, 24'($urandom)});
    add_option(8'd200, 5, $urandom);
    add_option(drp_pkg::OPT_SERVER, 4, $urandom);
    add_option(drp_pkg::OPT_MASK, 4, $urandom);
    add_option(drp_pkg::OPT_MASK, 4, $urandom);
    add_option(drp_pkg::OPT_DNS, 4, $urandom);
    cut_to(pkt.size() - 2);
    send_packet(drp_pkg::SERVER_PORT, ip_pool[3]);

    // The holder of the server id clears it with a zero value.
    start_reply();
    add_option(drp_pkg::OPT_SERVER, 4, '0);
    add_option(drp_pkg::OPT_TYPE, 1, '0);
    send_packet(drp_pkg::SERVER_PORT, ip_pool[2]);

    finish_phase();

    // Random rounds, each under its own setting; only the all-zero and all-one settings are reached.
    round = 0;
    while (round < 2) begin
      case (round % 5)
        0:       write_setting('0, '0);
        1:       write_setting('1, '1);
        2:       write_setting('0, '1);
        3:       write_setting('1, '0);
        default: write_setting({16'($urandom), 32'($urandom)}, $urandom);
      endcase
      send_random_reply();
      finish_phase();

      // Flood of tiny packets while the receiver holds off: the output
      // register fills, the closing byte waits and the input stalls.
      if (round == 1) begin
        flooding <= 1'b1;
        repeat (80) begin
          pkt.delete();
          repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
          if ($urandom_range(0, 1)) pkt[0] = drp_pkg::OP_REPLY;
          send_packet($urandom_range(0, 1) ? drp_pkg::SERVER_PORT : 16'($urandom), pick_ip());
        end
        finish_phase();
        flooding <= 1'b0;
      end
      round++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
